// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the buddy block allocator.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BBA_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BBA_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bba_pkg.sv
// Shared types, constants and tree helper functions of the buddy block allocator.
// No dependencies; used by the controller, the datapath and the top level.
package bba_pkg;

  localparam int SLOT_BYTES  = 65536;
  localparam int TOTAL_BYTES = 1048576;
  localparam int NUM_LEVELS  = 5;

  localparam int NODES  = (1 << NUM_LEVELS) - 1;
  localparam int ID_W   = $clog2(NODES + 1);
  localparam int POS_W  = (NUM_LEVELS > 1) ? NUM_LEVELS - 1 : 1;
  localparam int LEAVES = 1 << (NUM_LEVELS - 1);
  localparam int SZ_W   = 32;

  // Field widths of the transaction ports.
  localparam int REQ_W = 21;
  localparam int OFF_W = 4;
  localparam int LVL_W = 3;
  localparam int ST_W  = 2;

  typedef enum logic [1:0] {
    NS_ABSENT = 2'd0,
    NS_FREE   = 2'd1,
    NS_ALLOC  = 2'd2,
    NS_SPLIT  = 2'd3
  } node_st_t;

  typedef enum logic [ST_W-1:0] {
    RS_OK       = 2'd0,
    RS_TOO_BIG  = 2'd1,
    RS_NO_FREE  = 2'd2,
    RS_BAD_FREE = 2'd3
  } res_st_t;

  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_LOAD      = 3'd1,
    OP_SIZE      = 3'd2,
    OP_SEARCH    = 3'd3,
    OP_SPLIT     = 3'd4,
    OP_ALLOC     = 3'd5,
    OP_FREE_NEXT = 3'd6,
    OP_FREE_HIT  = 3'd7
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    err;
    res_st_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic fits;
    logic found;
    logic last_level;
    logic at_need;
    logic free_hit;
    logic free_stop;
  } dp_sts_t;

  // Heap index of the first node on a level; the root is the top level.
  function automatic logic [ID_W-1:0] level_base(input logic [LVL_W-1:0] l);
    return ID_W'((1 << (NUM_LEVELS - 1 - int'(l))) - 1);
  endfunction

  function automatic int level_count(input logic [LVL_W-1:0] l);
    return 1 << (NUM_LEVELS - 1 - int'(l));
  endfunction

  function automatic logic [SZ_W-1:0] block_bytes(input int l);
    return SZ_W'(SLOT_BYTES) << l;
  endfunction

endpackage

// File: rtl/bba_ctrl.sv
// Controller of the buddy block allocator: sequences size check, level search,
// splitting and release. Depends on bba_pkg; drives the datapath by command.
module bba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  bba_pkg::dp_sts_t sts,
  output bba_pkg::dp_cmd_t cmd
);
  import bba_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SIZE   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_SPLIT  = 5'b01000,
    S_FREE   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   emit;
  logic   can_emit;

  // The result register may be refilled once its transaction has gone.
  assign can_emit = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.err    = 1'b0;
    cmd.code   = RS_OK;
    emit       = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_SIZE;
        end
      end
      S_SIZE: begin
        if (sts.is_free) begin
          state_next = S_FREE;
        end else if (!sts.fits) begin
          if (can_emit) begin
            cmd.err    = 1'b1;
            cmd.code   = RS_TOO_BIG;
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op     = OP_SIZE;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.found) begin
          cmd.op     = OP_SEARCH;
          state_next = S_SPLIT;
        end else if (sts.last_level) begin
          if (can_emit) begin
            cmd.err    = 1'b1;
            cmd.code   = RS_NO_FREE;
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op = OP_SEARCH;
        end
      end
      S_SPLIT: begin
        if (sts.at_need) begin
          if (can_emit) begin
            cmd.op     = OP_ALLOC;
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op = OP_SPLIT;
        end
      end
      S_FREE: begin
        if (sts.free_hit) begin
          if (can_emit) begin
            cmd.op     = OP_FREE_HIT;
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end else if (sts.free_stop) begin
          if (can_emit) begin
            cmd.err    = 1'b1;
            cmd.code   = RS_BAD_FREE;
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op = OP_FREE_NEXT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/bba_dpath.sv
// Datapath of the buddy block allocator: block state tree, search and split
// registers, and the result register. Depends on bba_pkg; driven by bba_ctrl.
module bba_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        action,
  input  logic [bba_pkg::REQ_W-1:0]   request_bytes,
  input  logic [bba_pkg::OFF_W-1:0]   free_offset,
  input  bba_pkg::dp_cmd_t            cmd,
  output bba_pkg::dp_sts_t            sts,
  output logic [bba_pkg::ST_W-1:0]    status,
  output logic [bba_pkg::OFF_W-1:0]   block_offset,
  output logic [bba_pkg::LVL_W-1:0]   block_level
);
  import bba_pkg::*;

  node_st_t             node [NODES];
  logic                 act;
  logic [REQ_W-1:0]     req;
  logic [OFF_W-1:0]     foff;
  logic [LVL_W-1:0]     need;
  logic [LVL_W-1:0]     lvl;
  logic [POS_W-1:0]     pos;
  logic [ID_W-1:0]      id;

  logic                 fits_c;
  logic                 any_lvl;
  logic [LVL_W-1:0]     need_c;
  logic                 found_c;
  logic [POS_W-1:0]     ff_c;
  logic [ID_W-1:0]      base_c;
  logic [ID_W-1:0]      scan_idx;
  logic [ID_W:0]        child_l;
  logic [ID_W:0]        child_r;
  logic [OFF_W-1:0]     lo_mask;
  logic [OFF_W-1:0]     pos_f;
  logic                 misaligned;
  logic                 in_range;
  logic [ID_W-1:0]      id_f;
  logic [OFF_W-1:0]     alloc_off;

  // Smallest level whose block holds the request.
  always_comb begin
    any_lvl = 1'b0;
    need_c  = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (!any_lvl && (block_bytes(l) >= SZ_W'(req))) begin
        any_lvl = 1'b1;
        need_c  = LVL_W'(l);
      end
    end
    fits_c = any_lvl && (SZ_W'(req) <= SZ_W'(TOTAL_BYTES));
  end

  // Lowest free block on the level under search; one level per cycle.
  assign base_c = level_base(lvl);
  always_comb begin
    found_c  = 1'b0;
    ff_c     = '0;
    scan_idx = '0;
    for (int p = 0; p < LEAVES; p++) begin
      scan_idx = base_c + ID_W'(p);
      if (!found_c && (p < level_count(lvl)) && (node[scan_idx] == NS_FREE)) begin
        found_c = 1'b1;
        ff_c    = POS_W'(p);
      end
    end
  end

  assign child_l = {id, 1'b1};
  assign child_r = {id, 1'b0} + (ID_W+1)'(2);

  // Release walks up from level 0 while the offset stays aligned.
  assign lo_mask    = (OFF_W'(1) << lvl) - OFF_W'(1);
  assign misaligned = |(foff & lo_mask);
  assign pos_f      = foff >> lvl;
  assign in_range   = int'(pos_f) < level_count(lvl);
  assign id_f       = base_c + ID_W'(pos_f);

  assign alloc_off = OFF_W'(pos) << need;

  always_comb begin
    sts.is_free    = act;
    sts.fits       = fits_c;
    sts.found      = found_c;
    sts.last_level = (lvl == LVL_W'(NUM_LEVELS - 1));
    sts.at_need    = (lvl == need);
    sts.free_hit   = !misaligned && in_range && (node[id_f] == NS_ALLOC);
    sts.free_stop  = misaligned || (lvl == LVL_W'(NUM_LEVELS - 1));
  end

  // Block state tree.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NODES; n++) begin
        node[n] <= (n == 0) ? NS_FREE : NS_ABSENT;
      end
    end else begin
      case (cmd.op)
        OP_SPLIT: begin
          node[id]                <= NS_SPLIT;
          node[child_l[ID_W-1:0]] <= NS_FREE;
          node[child_r[ID_W-1:0]] <= NS_FREE;
        end
        OP_ALLOC: begin
          node[id] <= NS_ALLOC;
        end
        OP_FREE_HIT: begin
          node[id_f] <= NS_FREE;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers and result register.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act  <= action;
        req  <= request_bytes;
        foff <= free_offset;
        lvl  <= '0;
      end
      OP_SIZE: begin
        need <= need_c;
        lvl  <= need_c;
      end
      OP_SEARCH: begin
        if (found_c) begin
          pos <= ff_c;
          id  <= base_c + ID_W'(ff_c);
        end else begin
          lvl <= lvl + LVL_W'(1);
        end
      end
      OP_SPLIT: begin
        id  <= child_l[ID_W-1:0];
        pos <= pos << 1;
        lvl <= lvl - LVL_W'(1);
      end
      OP_ALLOC: begin
        status       <= RS_OK;
        block_offset <= alloc_off;
        block_level  <= need;
      end
      OP_FREE_NEXT: begin
        lvl <= lvl + LVL_W'(1);
      end
      OP_FREE_HIT: begin
        status       <= RS_OK;
        block_offset <= foff;
        block_level  <= lvl;
      end
      default: begin
      end
    endcase
    if (cmd.err) begin
      status       <= cmd.code;
      block_offset <= '0;
      block_level  <= '0;
    end
  end

endmodule

// File: rtl/buddy_block_allocator_core.sv
// Buddy block allocator over a 31-node block tree; one transaction at a time.
// Allocate checks the size, searches the levels upwards from the needed one, then splits.
// Free walks up the levels from the slot until it meets the allocated block.
// The result register lets the next transaction enter while a result waits.
// Synchronous reset leaves the root block free and all other blocks absent.
`include "assert_macros.svh"

module buddy_block_allocator_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic [bba_pkg::REQ_W-1:0]   request_bytes,
  input  logic [bba_pkg::OFF_W-1:0]   free_offset,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bba_pkg::ST_W-1:0]    status,
  output logic [bba_pkg::OFF_W-1:0]   block_offset,
  output logic [bba_pkg::LVL_W-1:0]   block_level
);
  import bba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bba_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .action        (action),
    .request_bytes (request_bytes),
    .free_offset   (free_offset),
    .cmd           (cmd),
    .sts           (sts),
    .status        (status),
    .block_offset  (block_offset),
    .block_level   (block_level)
  );

  `BBA_ASSERT_IMP(a_err_fields_zero, clk, rst, out_valid && (status != RS_OK), (block_offset == '0) && (block_level == '0), "error result carries a block")
  `BBA_ASSERT_IMP(a_level_range, clk, rst, out_valid, int'(block_level) < NUM_LEVELS, "result level beyond the tree")
  `BBA_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall, "transaction accepted while still idle")

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for buddy_block_allocator_core: allocate and free transactions
// are checked against a predictor of the block tree kept inside this file.
// Depends on bba_pkg for the field widths, node states and result codes.
`timescale 1ns / 1ps

module tb_top;
  import bba_pkg::*;

  localparam bit ACT_ALLOC = 1'b0;
  localparam bit ACT_FREE  = 1'b1;
  localparam int RANDOM_REQUESTS = 1750;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    bit               act;
    logic [REQ_W-1:0] bytes;
    logic [OFF_W-1:0] off;
    bit               drain_first;
  } alloc_req_t;

  typedef struct packed {
    res_st_t          st;
    logic [OFF_W-1:0] off;
    logic [LVL_W-1:0] lvl;
  } alloc_reply_t;

  logic             clk;
  logic             rst;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             action = ACT_ALLOC;
  logic [REQ_W-1:0] request_bytes = '0;
  logic [OFF_W-1:0] free_offset = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ST_W-1:0]  status;
  logic [OFF_W-1:0] block_offset;
  logic [LVL_W-1:0] block_level;

  node_st_t     tree [NODES];
  alloc_req_t   request_backlog [$];
  alloc_reply_t awaited_replies [$];
  alloc_req_t   offered;
  alloc_reply_t want;

  int  mismatches = 0;
  int  accepted_count = 0;
  int  status_tally [4] = '{0, 0, 0, 0};
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  calm = 1'b0;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;
  bit  took;

  buddy_block_allocator_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .request_bytes (request_bytes),
    .free_offset   (free_offset),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .block_offset  (block_offset),
    .block_level   (block_level)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #3000000;
    $display("%0t: timed out with %0d replies outstanding", $time, awaited_replies.size());
    $display("status: fail");
    $finish;
  end

  function automatic int draw_wait();
    if (calm)
      return 0;
    return $urandom_range(0, 6);
  endfunction

  // Applies one transaction to the tree copy and returns the reply it should produce.
  // Row l of the heap starts at node (LEAVES >> l) - 1 and holds LEAVES >> l blocks.
  function automatic alloc_reply_t serve_request(input bit act, input logic [REQ_W-1:0] bytes,
                                                 input logic [OFF_W-1:0] off);
    alloc_reply_t r;
    int  need;
    int  at;
    int  pos;
    int  id;
    bit  found;
    bit  stop;
    r.st  = RS_OK;
    r.off = '0;
    r.lvl = '0;
    if (act == ACT_ALLOC) begin
      need = -1;
      if (bytes <= TOTAL_BYTES) begin
        for (int l = 0; l < NUM_LEVELS; l++)
          if (need < 0 && (longint'(SLOT_BYTES) << l) >= longint'(bytes))
            need = l;
      end
      if (need < 0) begin
        r.st = RS_TOO_BIG;
        return r;
      end
      found = 1'b0;
      at = 0;
      pos = 0;
      for (int l = need; l < NUM_LEVELS; l++)
        for (int p = 0; p < (LEAVES >> l); p++)
          if (!found && tree[(LEAVES >> l) - 1 + p] == NS_FREE) begin
            found = 1'b1;
            at = l;
            pos = p;
          end
      if (!found) begin
        r.st = RS_NO_FREE;
        return r;
      end
      // Split down to the needed size, always carrying on in the left half.
      id = (LEAVES >> at) - 1 + pos;
      while (at > need) begin
        tree[id] = NS_SPLIT;
        tree[2 * id + 1] = NS_FREE;
        tree[2 * id + 2] = NS_FREE;
        id = 2 * id + 1;
        pos = pos * 2;
        at--;
      end
      tree[id] = NS_ALLOC;
      r.off = OFF_W'(pos << need);
      r.lvl = LVL_W'(need);
      return r;
    end
    stop = 1'b0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if ((int'(off) & ((1 << l) - 1)) != 0)
        stop = 1'b1;
      if (!stop && (int'(off) >> l) < (LEAVES >> l)) begin
        id = (LEAVES >> l) - 1 + (int'(off) >> l);
        if (tree[id] == NS_ALLOC) begin
          tree[id] = NS_FREE;
          r.off = off;
          r.lvl = LVL_W'(l);
          return r;
        end
      end
    end
    r.st = RS_BAD_FREE;
    return r;
  endfunction

  // Driver: offers the backlog one transaction at a time, holding it while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      for (int n = 0; n < NODES; n++)
        tree[n] = NS_ABSENT;
      tree[0] = NS_FREE;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        want = serve_request(offered.act, offered.bytes, offered.off);
        awaited_replies.push_back(want);
        status_tally[want.st]++;
        accepted_count++;
        gap_left = draw_wait();
      end
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_backlog.size() > 0 &&
                     !(request_backlog[0].drain_first && awaited_replies.size() > 0)) begin
          offered = request_backlog.pop_front();
          action <= offered.act;
          request_bytes <= offered.bytes;
          free_offset <= offered.off;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each reply against the oldest prediction and throttles the output.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          mismatches++;
          $display("%0t: reply with nothing outstanding: status %0d offset %0d level %0d",
                   $time, status, block_offset, block_level);
        end else begin
          alloc_reply_t w;
          w = awaited_replies.pop_front();
          if (status !== w.st) begin
            mismatches++;
            $display("%0t: status expected %0d got %0d", $time, w.st, status);
          end
          if (block_offset !== w.off) begin
            mismatches++;
            $display("%0t: block_offset expected %0d got %0d", $time, w.off, block_offset);
          end
          if (block_level !== w.lvl) begin
            mismatches++;
            $display("%0t: block_level expected %0d got %0d", $time, w.lvl, block_level);
          end
        end
        stall_left = draw_wait();
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_alloc(input int bytes);
    alloc_req_t q;
    q.act = ACT_ALLOC;
    q.bytes = REQ_W'(bytes);
    q.off = OFF_W'($urandom);
    q.drain_first = 1'b0;
    request_backlog.push_back(q);
  endtask

  task automatic push_free(input int off);
    alloc_req_t q;
    q.act = ACT_FREE;
    q.bytes = REQ_W'($urandom);
    q.off = OFF_W'(off);
    q.drain_first = 1'b0;
    request_backlog.push_back(q);
  endtask

  initial begin
    int live [$];
    int pick;
    int lvl;
    int lo;
    int hi;
    @(negedge rst);

    // Directed part: size edges, oversize, exhaustion, splits and every kind of bad free.
    push_alloc(0);
    push_alloc(1);
    push_alloc(SLOT_BYTES);
    push_alloc(SLOT_BYTES + 1);
    push_alloc(2 * SLOT_BYTES);
    push_alloc(TOTAL_BYTES + 1);
    push_alloc((1 << REQ_W) - 1);
    push_alloc(TOTAL_BYTES);
    push_alloc(TOTAL_BYTES / 2);
    push_alloc(4 * SLOT_BYTES + 1);
    push_free(3);
    push_free(2);
    push_free(4);
    push_free(8);
    push_free(8);
    push_free(5);
    push_free(15);
    push_free(0);
    push_alloc(4 * SLOT_BYTES);
    push_free(12);
    push_free(6);
    push_alloc(1);
    push_free(0);
    push_free(1);
    push_free(8);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      while (request_backlog.size() > 3)
        @(posedge clk);
      calm = ((i / 250) % 3 == 1);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // Well-formed allocation, sizes clustered on the level boundaries.
        lvl = $urandom_range(0, NUM_LEVELS - 1);
        hi = SLOT_BYTES << lvl;
        lo = (lvl == 0) ? 0 : (SLOT_BYTES << (lvl - 1)) + 1;
        case ($urandom_range(0, 3))
          0:       push_alloc(hi);
          1:       push_alloc(lo);
          default: push_alloc($urandom_range(lo, hi));
        endcase
      end else if (pick < 85) begin
        // Release a block that the tree currently holds as allocated, or a random slot if none is.
        live.delete();
        for (int l = 0; l < NUM_LEVELS; l++)
          for (int p = 0; p < (LEAVES >> l); p++)
            if (tree[(LEAVES >> l) - 1 + p] == NS_ALLOC)
              live.push_back(p << l);
        if (live.size() > 0)
          push_free(live[$urandom_range(0, live.size() - 1)]);
        else
          push_free($urandom_range(0, LEAVES - 1));
      end else if (pick < 92) begin
        push_alloc($urandom_range(0, (1 << REQ_W) - 1));
      end else begin
        push_free($urandom_range(0, (1 << OFF_W) - 1));
      end
      if (i == 600)
        request_backlog[request_backlog.size() - 1].drain_first = 1'b1;
      if (i == 900)
        long_hold_req = 1'b1;
    end

    while (request_backlog.size() > 0 || in_valid || awaited_replies.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d transactions: %0d granted or released, %0d oversize,",
             accepted_count, status_tally[RS_OK], status_tally[RS_TOO_BIG]);
    $display("%0d refused for want of a free block and %0d rejected frees.",
             status_tally[RS_NO_FREE], status_tally[RS_BAD_FREE]);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_ctrl.sv
rtl/bba_dpath.sv
rtl/buddy_block_allocator_core.sv
verif/tb_top.sv
